/* sv/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg - shared types and codes for the selective-repeat sender
// Slot and control types for the chain of window cells, event and
// result codes, and the reset value of the timeout register.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int TICK_W = 32;

   // event codes on req_op
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_ACK   = 2'd2;

   // result codes on rsp_kind
   localparam logic [1:0] KIND_FIRST    = 2'd0;
   localparam logic [1:0] KIND_RESEND   = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;

   localparam logic [23:0] TIMEOUT_RESET = 24'd100000;

   // one window slot: chunk acked, tick at which it was last sent
   typedef struct packed {
      logic              acked;
      logic [TICK_W-1:0] sent_at;
   } srs_slot_type;

   // commands broadcast to every cell of the chain
   typedef struct packed {
      logic shift;    // rotate: each cell takes its upper neighbor
      logic refresh;  // on rotate, restamp the head slot with the current tick
      logic mark;     // set acked in the addressed cell
      logic load;     // open a fresh slot in the addressed cell
   } srs_ctrl_type;

endpackage

/* sv/srs_cell.sv */
// ----------------------------------------------------------------------------
// srs_cell - one window slot
// Holds the acked flag and send tick of one chunk. Takes its neighbor's
// slot on a rotate, or is marked or loaded when the broadcast position
// matches its own place in the chain.
// ----------------------------------------------------------------------------
module srs_cell #(
   parameter int PW,
   parameter int CELL_IDX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srs_pkg::srs_ctrl_type  ctrl,
   input  logic [PW-1:0]          pos,
   input  logic [srs_pkg::TICK_W-1:0] now,
   input  srs_pkg::srs_slot_type  shift_in,
   output srs_pkg::srs_slot_type  slot
);

   srs_pkg::srs_slot_type slot_ff;
   srs_pkg::srs_slot_type slot_in;
   logic                  here;

   assign here = (pos == PW'(CELL_IDX));
   assign slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.shift) begin
         slot_in = shift_in;
      end else if (ctrl.load && here) begin
         slot_in.acked   = 1'b0;
         slot_in.sent_at = now;
      end else if (ctrl.mark && here) begin
         slot_in.acked = 1'b1;
      end
   end

   // send tick is only read once loaded, so it takes no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.acked <= 1'b0;
      end else begin
         slot_ff.acked <= slot_in.acked;
      end
      slot_ff.sent_at <= slot_in.sent_at;
   end

endmodule

/* sv/srs_chain.sv */
// ----------------------------------------------------------------------------
// srs_chain - ring of window cells
// Cell 0 holds the oldest unacked chunk. A rotate moves every slot one
// place toward the head and feeds the head slot, optionally restamped,
// back in at the tail.
// ----------------------------------------------------------------------------
module srs_chain #(
   parameter int WINDOW,
   parameter int PW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srs_pkg::srs_ctrl_type  ctrl,
   input  logic [PW-1:0]          pos,
   input  logic [srs_pkg::TICK_W-1:0] now,
   output srs_pkg::srs_slot_type  head
);

   srs_pkg::srs_slot_type cell_q [WINDOW];
   srs_pkg::srs_slot_type tail_feed;

   assign head = cell_q[0];

   always_comb begin
      tail_feed = cell_q[0];
      if (ctrl.refresh) begin
         tail_feed.sent_at = now;
      end
   end

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      srs_pkg::srs_slot_type nbr;
      if (k == WINDOW - 1) begin : g_tail
         assign nbr = tail_feed;
      end else begin : g_body
         assign nbr = cell_q[k+1];
      end
      srs_cell #(
         .PW       (PW),
         .CELL_IDX (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .pos      (pos),
         .now      (now),
         .shift_in (nbr),
         .slot     (cell_q[k])
      );
   end

endmodule

/* sv/selective_repeat_sender_unit.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_unit - selective-repeat ARQ sender
// Window of WINDOW chunk slots kept as a ring of cells. Start, tick and
// ack events drive first sends, timed retransmits and completion.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | payload
//   req     | in  | req_valid/req_stall | op, chunk_count, ack_seq
//   rsp     | out | rsp_valid/rsp_stall | kind, chunk_seq, last
//   csr     | in  | csr_valid/csr_ready | timeout_ticks
//
// One event at a time; req_stall is high while an event is in work.
// Start fills the window, a busy tick rotates the ring, an ack slides and
// refills it; idle ticks and ignored events need no walk. The controller
// visits one cell of the slot chain per cycle (rotate, slide, fill).
// Each walk step waits while the output register is full and stalled.
// Synchronous reset clears control state; slot send ticks are left as they are.
// ----------------------------------------------------------------------------
module selective_repeat_sender_unit #(
   parameter int WINDOW   = 5,
   parameter int SEQ_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_chunk_count,
   input  logic [7:0]  req_ack_seq,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_chunk_seq,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_timeout_ticks
);

   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int OFF_W = (SEQ_BITS > 8) ? SEQ_BITS : 8;
   localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((33'd1 << SEQ_BITS) - 33'd1);
   localparam logic [7:0] OUT_MASK = OFF_MASK[7:0];

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_SLIDE,
      S_ADMIT,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [7:0]  base_ff, base_in;
   logic [7:0]  next_ff, next_in;
   logic [7:0]  total_ff, total_in;
   logic [srs_pkg::TICK_W-1:0] now_ff, now_in;
   logic [23:0] timeout_ff, timeout_in;
   logic [PW-1:0] step_ff, step_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic [7:0]  pend_seq_ff, pend_seq_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_seq_ff, rsp_seq_in;
   logic        rsp_last_ff, rsp_last_in;

   srs_pkg::srs_ctrl_type ctrl;
   srs_pkg::srs_slot_type head;
   logic [PW-1:0] pos;
   logic [7:0]    win_count;
   logic [OFF_W-1:0] ack_off;
   logic          ack_hit;
   logic [srs_pkg::TICK_W-1:0] age;
   logic          tick_hit;
   logic          out_free;
   logic          gen;
   logic [1:0]    gen_kind;
   logic [7:0]    gen_seq;
   logic          fin;

   srs_chain #(
      .WINDOW (WINDOW),
      .PW     (PW)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .pos   (pos),
      .now   (now_ff),
      .head  (head)
   );

   assign win_count = next_ff - base_ff;
   assign ack_off   = (OFF_W'(req_ack_seq) - OFF_W'(base_ff)) & OFF_MASK;
   assign ack_hit   = (ack_off < OFF_W'(win_count));
   assign age       = now_ff - head.sent_at;
   assign tick_hit  = (8'(step_ff) < win_count) && !head.acked &&
                      (age > srs_pkg::TICK_W'(timeout_ff));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_chunk_seq = rsp_seq_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      base_in       = base_ff;
      next_in       = next_ff;
      total_in      = total_ff;
      now_in        = now_ff;
      timeout_in    = timeout_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl          = '0;
      pos           = '0;
      gen           = 1'b0;
      gen_kind      = srs_pkg::KIND_FIRST;
      gen_seq       = '0;
      fin           = 1'b0;

      if (csr_valid && csr_ready) begin
         timeout_in = csr_timeout_ticks;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  srs_pkg::OP_START: begin
                     if (!busy_ff) begin
                        base_in  = '0;
                        next_in  = '0;
                        total_in = req_chunk_count;
                        if (req_chunk_count == 8'd0) begin
                           gen      = 1'b1;
                           gen_kind = srs_pkg::KIND_COMPLETE;
                           state_in = S_FINISH;
                        end else begin
                           busy_in  = 1'b1;
                           state_in = S_ADMIT;
                        end
                     end
                  end
                  srs_pkg::OP_TICK: begin
                     now_in = now_ff + 1'b1;
                     if (busy_ff) begin
                        step_in  = '0;
                        state_in = S_TICK;
                     end
                  end
                  srs_pkg::OP_ACK: begin
                     if (busy_ff && ack_hit) begin
                        ctrl.mark = 1'b1;
                        pos       = ack_off[PW-1:0];
                        state_in  = S_SLIDE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TICK: begin
            // rotate the full ring once; the head cell is checked at each rotate step
            if (out_free) begin
               ctrl.shift   = 1'b1;
               ctrl.refresh = tick_hit;
               if (tick_hit) begin
                  gen      = 1'b1;
                  gen_kind = srs_pkg::KIND_RESEND;
                  gen_seq  = base_ff + 8'(step_ff);
               end
               if (step_ff == PW'(WINDOW - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         S_SLIDE: begin
            if (out_free) begin
               if (win_count != 8'd0 && head.acked) begin
                  // drop the acked head; its cell comes back as a free tail
                  ctrl.shift = 1'b1;
                  base_in    = base_ff + 1'b1;
               end else if (base_ff >= total_ff) begin
                  busy_in  = 1'b0;
                  gen      = 1'b1;
                  gen_kind = srs_pkg::KIND_COMPLETE;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_ADMIT;
               end
            end
         end
         S_ADMIT: begin
            if (out_free) begin
               if (next_ff < total_ff && win_count < 8'(WINDOW)) begin
                  ctrl.load = 1'b1;
                  pos       = win_count[PW-1:0];
                  gen       = 1'b1;
                  gen_kind  = srs_pkg::KIND_FIRST;
                  gen_seq   = next_ff;
                  next_in   = next_ff + 1'b1;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      // hold each result one step so the final one can carry last
      if (gen) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = pend_kind_ff;
            rsp_seq_in   = pend_seq_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_kind_in  = gen_kind;
         pend_seq_in   = gen_seq & OUT_MASK;
      end
      if (fin && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = pend_kind_ff;
         rsp_seq_in    = pend_seq_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= 1'b0;
         base_ff       <= '0;
         next_ff       <= '0;
         total_ff      <= '0;
         now_ff        <= '0;
         timeout_ff    <= srs_pkg::TIMEOUT_RESET;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         base_ff       <= base_in;
         next_ff       <= next_in;
         total_ff      <= total_in;
         now_ff        <= now_in;
         timeout_ff    <= timeout_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         pend_kind_ff  <= pend_kind_in;
         pend_seq_ff   <= pend_seq_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_seq_ff    <= rsp_seq_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for selective_repeat_sender_unit
// Feeds start, tick and ack events, including ignored and malformed ones,
// through a driver queue. Each accepted event is run through an in-bench
// window predictor, and the result stream is compared in order against it.
// The timeout register is rewritten between phases, from 1 to its maximum, and
// both channels stall at random. One long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb;

   localparam int WIN          = 5;
   localparam int MAX_RSP      = 8;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] count;
      logic [7:0] ack;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] seq;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      int unsigned          base;
      int unsigned          nxt;
      int unsigned          total;
      logic                 busy;
      logic [31:0]          now;
      logic [WIN-1:0]       acked;
      logic [WIN-1:0][31:0] sent_at;
      logic [23:0]          timeout;
   } arq_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_NONE;
   logic [7:0]  req_chunk_count = '0;
   logic [7:0]  req_ack_seq = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_chunk_seq;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_timeout_ticks = '0;

   req_item_type  req_pending[$];
   rsp_item_type  due_rsp[$];
   arq_state_type model_arq;   // follows the events the block has accepted
   arq_state_type plan_arq;    // follows the events queued for driving
   int            req_sent = 0;
   int            req_accepts = 0;
   int            plan_count = 0;
   int            err_count = 0;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   logic          hold_go = 1'b0;
   logic          rx_hold = 1'b0;

   selective_repeat_sender_unit #(
      .WINDOW   (WIN),
      .SEQ_BITS (8)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_chunk_count   (req_chunk_count),
      .req_ack_seq       (req_ack_seq),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_chunk_seq     (rsp_chunk_seq),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one event to a window state and list the send commands it causes.
   function automatic int arq_step(inout arq_state_type st, input req_item_type ev,
                                   output rsp_item_type [MAX_RSP-1:0] rsp);
      int          n;
      int unsigned s;
      logic [7:0]  off;
      logic        open_more;
      n = 0;
      open_more = 1'b0;
      rsp = '0;
      case (ev.op)
         srs_pkg::OP_START: begin
            if (!st.busy) begin
               st.base  = 0;
               st.nxt   = 0;
               st.total = ev.count;
               st.acked = '0;
               if (ev.count == 8'd0) begin
                  rsp[n] = '{kind: srs_pkg::KIND_COMPLETE, seq: 8'd0, last: 1'b0};
                  n++;
               end else begin
                  st.busy   = 1'b1;
                  open_more = 1'b1;
               end
            end
         end
         srs_pkg::OP_TICK: begin
            st.now = st.now + 32'd1;
            if (st.busy) begin
               for (s = st.base; s < st.nxt; s++) begin
                  if (!st.acked[s % WIN] &&
                      (st.now - st.sent_at[s % WIN]) > 32'(st.timeout)) begin
                     st.sent_at[s % WIN] = st.now;
                     rsp[n] = '{kind: srs_pkg::KIND_RESEND, seq: 8'(s), last: 1'b0};
                     n++;
                  end
               end
            end
         end
         srs_pkg::OP_ACK: begin
            if (st.busy) begin
               off = ev.ack - 8'(st.base);
               if (32'(off) < st.nxt - st.base) begin
                  st.acked[(st.base + off) % WIN] = 1'b1;
                  // slide past the leading acked chunks
                  while (st.base < st.nxt && st.acked[st.base % WIN]) begin
                     st.acked[st.base % WIN] = 1'b0;
                     st.base++;
                  end
                  if (st.base >= st.total) begin
                     st.busy = 1'b0;
                     rsp[n] = '{kind: srs_pkg::KIND_COMPLETE, seq: 8'd0, last: 1'b0};
                     n++;
                  end else begin
                     open_more = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      if (open_more) begin
         while (st.nxt < st.total && st.nxt < st.base + WIN) begin
            st.acked[st.nxt % WIN]   = 1'b0;
            st.sent_at[st.nxt % WIN] = st.now;
            rsp[n] = '{kind: srs_pkg::KIND_FIRST, seq: 8'(st.nxt), last: 1'b0};
            n++;
            st.nxt++;
         end
      end
      if (n > 0)
         rsp[n-1].last = 1'b1;
      return n;
   endfunction

   // Driver: hold the payload until the transaction is taken.
   always @(negedge clock) begin : req_driver
      req_item_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts == req_sent) begin
         if (req_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            ev = req_pending.pop_front();
            req_valid       <= 1'b1;
            req_op          <= ev.op;
            req_chunk_count <= ev.count;
            req_ack_seq     <= ev.ack;
            req_sent        <= req_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : req_accept
      req_item_type                ev;
      rsp_item_type [MAX_RSP-1:0] batch;
      int                          n;
      if (!reset && req_valid && !req_stall) begin
         ev.op    = req_op;
         ev.count = req_chunk_count;
         ev.ack   = req_ack_seq;
         n = arq_step(model_arq, ev, batch);
         for (int i = 0; i < n; i++)
            due_rsp.push_back(batch[i]);
         req_accepts++;
      end
   end

   always @(negedge clock) begin : rsp_receiver
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
   end

   // Long receiver hold-off while the sender keeps offering transactions.
   initial begin : rx_hold_counter
      wait (hold_go);
      @(negedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rx_hold <= 1'b0;
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            $error("unexpected result: kind %0d chunk_seq %0d last %0d",
                   rsp_kind, rsp_chunk_seq, rsp_last);
            err_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("rsp_kind: expected %0d, got %0d", want.kind, rsp_kind);
               err_count++;
            end
            if (rsp_chunk_seq !== want.seq) begin
               $error("rsp_chunk_seq: expected %0d, got %0d", want.seq, rsp_chunk_seq);
               err_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
               err_count++;
            end
         end
      end
   end

   task automatic plan(input logic [1:0] op, input logic [7:0] cnt, input logic [7:0] ack);
      req_item_type                ev;
      rsp_item_type [MAX_RSP-1:0] unused;
      int                          n;
      ev.op    = op;
      ev.count = cnt;
      ev.ack   = ack;
      req_pending.push_back(ev);
      n = arq_step(plan_arq, ev, unused);
      plan_count++;
   endtask

   // One message from start to completion, with ticks and noise mixed in.
   task automatic plan_message(input logic [7:0] chunks);
      int unsigned span;
      int          r;
      plan(srs_pkg::OP_START, chunks, 8'($urandom));
      while (plan_arq.busy) begin
         r    = $urandom_range(99);
         span = plan_arq.nxt - plan_arq.base;
         if (r < 30)
            plan(srs_pkg::OP_ACK, 8'($urandom), 8'(plan_arq.base));
         else if (r < 58)
            plan(srs_pkg::OP_ACK, 8'($urandom),
                 8'(plan_arq.base + $urandom_range(span - 1)));
         else if (r < 82)
            repeat ($urandom_range(3, 1)) plan(srs_pkg::OP_TICK, 8'($urandom), 8'($urandom));
         else if (r < 89)
            plan(srs_pkg::OP_ACK, 8'($urandom), 8'($urandom));
         else if (r < 95)
            plan(srs_pkg::OP_START, 8'($urandom), 8'($urandom));
         else
            plan(OP_NONE, 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic plan_random(input int quota);
      int stop_at;
      stop_at = plan_count + quota;
      while (plan_count < stop_at) begin
         case ($urandom_range(9))
            0:       plan(srs_pkg::OP_TICK, 8'($urandom), 8'($urandom));
            1:       plan(srs_pkg::OP_ACK, 8'($urandom), 8'($urandom));
            2:       plan_message(8'd0);
            default: plan_message(8'($urandom_range(12, 1)));
         endcase
      end
   endtask

   task automatic drain();
      while (req_pending.size() != 0 || req_valid || due_rsp.size() != 0)
         @(posedge clock);
      // acks that cause nothing may still be walking the window
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [23:0] value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_timeout_ticks <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_arq.timeout = value;
      plan_arq.timeout  = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : main
      model_arq         = '0;
      model_arq.timeout = srs_pkg::TIMEOUT_RESET;
      plan_arq          = model_arq;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 32;
      rx_idle_pct = 84;
      write_timeout(24'd1);
      plan(OP_NONE,           8'hFF, 8'hFF);   // undefined op, all ones
      plan(srs_pkg::OP_TICK,  8'h00, 8'h00);   // tick while idle
      plan(srs_pkg::OP_ACK,   8'h5A, 8'h00);   // ack while idle
      plan(srs_pkg::OP_START, 8'h00, 8'hA5);   // empty message
      plan(srs_pkg::OP_START, 8'h03, 8'h00);
      plan(srs_pkg::OP_START, 8'hFF, 8'h00);   // start while busy
      plan(srs_pkg::OP_ACK,   8'h00, 8'h07);   // chunk not yet sent
      plan(srs_pkg::OP_ACK,   8'h00, 8'h01);   // out of order, window holds
      plan(srs_pkg::OP_TICK,  8'h00, 8'h00);
      plan(srs_pkg::OP_TICK,  8'h00, 8'h00);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h01);   // duplicate
      plan(srs_pkg::OP_ACK,   8'h00, 8'h00);   // slide by two
      plan(srs_pkg::OP_ACK,   8'h00, 8'hFF);   // behind the window
      plan(srs_pkg::OP_TICK,  8'h00, 8'h00);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h02);   // completes
      plan(srs_pkg::OP_START, 8'h08, 8'h00);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h00);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h04);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h03);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h02);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h01);   // full slide, admit the tail
      plan(srs_pkg::OP_TICK,  8'h00, 8'h00);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h07);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h06);
      plan(srs_pkg::OP_ACK,   8'h00, 8'h05);
      drain();

      write_timeout(24'd3);
      plan_random(20);
      drain();

      tx_idle_pct = 84;
      rx_idle_pct = 32;
      write_timeout(24'hFFFFFF);
      plan_random(20);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_timeout(24'd2);
      hold_go = 1'b1;
      plan_random(15);
      drain();

      if (err_count == 0 && due_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
